@@ hdl/tgc_pkg.sv @@
`default_nettype none

package tgc_pkg;

	// Event codes reported per poll sample.
	localparam int EVENT_W = 3;
	localparam logic [EVENT_W-1:0] EV_IDLE     = 3'd0;
	localparam logic [EVENT_W-1:0] EV_DOWN     = 3'd1;
	localparam logic [EVENT_W-1:0] EV_MOVE     = 3'd2;
	localparam logic [EVENT_W-1:0] EV_KEEP     = 3'd3;
	localparam logic [EVENT_W-1:0] EV_KEEPMOVE = 3'd4;
	localparam logic [EVENT_W-1:0] EV_UP       = 3'd5;
	localparam logic [EVENT_W-1:0] EV_UPKEEP   = 3'd6;

	// Configuration register map.
	localparam int RANGE_W    = 12;
	localparam int LIMIT_W    = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam logic [CFG_IDX_W-1:0] CFG_X_RANGE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_RANGE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_LIMIT = 2'd2;

	localparam logic [RANGE_W-1:0] X_RANGE_RST    = 12'd16;
	localparam logic [RANGE_W-1:0] Y_RANGE_RST    = 12'd16;
	localparam logic [LIMIT_W-1:0] HOLD_LIMIT_RST = 8'd5;

	// Result stream: the event code padded to one byte.
	localparam int OUT_TDATA_W = 8;

	typedef struct packed {
		logic [RANGE_W-1:0] x_range;
		logic [RANGE_W-1:0] y_range;
		logic [LIMIT_W-1:0] hold_limit;
	} cfg_t;

endpackage

`default_nettype wire

@@ hdl/tgc_step.sv @@
`default_nettype none

// Next-state logic for one poll sample: release handling, first touch,
// hold counting and the movement test against the last coordinates.
module tgc_step #(
	parameter int COORD_BITS = 12,
	parameter int COUNT_BITS = 8
) (
	input  wire  tgc_pkg::cfg_t             cfg,
	input  wire  [tgc_pkg::EVENT_W-1:0]     state,
	input  wire  [COUNT_BITS-1:0]           count,
	input  wire  [COORD_BITS-1:0]           last_x,
	input  wire  [COORD_BITS-1:0]           last_y,
	input  wire                             touched,
	input  wire  [COORD_BITS-1:0]           x_pos,
	input  wire  [COORD_BITS-1:0]           y_pos,
	output logic [tgc_pkg::EVENT_W-1:0]     state_nxt,
	output logic [COUNT_BITS-1:0]           count_nxt,
	output logic [COORD_BITS-1:0]           last_x_nxt,
	output logic [COORD_BITS-1:0]           last_y_nxt
);
	import tgc_pkg::*;

	localparam int DW = (COORD_BITS > RANGE_W) ? COORD_BITS : RANGE_W;
	localparam int CW = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

	logic [COORD_BITS-1:0] dx;
	logic [COORD_BITS-1:0] dy;
	logic [COUNT_BITS-1:0] count_inc;
	logic                  hold_ok;
	logic                  move_ok;

	assign dx = (x_pos >= last_x) ? (x_pos - last_x) : (last_x - x_pos);
	assign dy = (y_pos >= last_y) ? (y_pos - last_y) : (last_y - y_pos);

	// The counter saturates at all ones.
	assign count_inc = (&count) ? count : (count + {{(COUNT_BITS-1){1'b0}}, 1'b1});

	assign hold_ok = (state == EV_KEEP) ||
		(CW'(count_inc) > CW'(cfg.hold_limit));
	assign move_ok = (state == EV_MOVE) ||
		(DW'(dx) > DW'(cfg.x_range)) || (DW'(dy) > DW'(cfg.y_range));

	always_comb begin
		state_nxt  = state;
		count_nxt  = count;
		last_x_nxt = last_x;
		last_y_nxt = last_y;
		if (!touched) begin
			case (state)
				EV_IDLE: state_nxt = EV_IDLE;
				EV_KEEP: state_nxt = EV_UPKEEP;
				EV_UP, EV_UPKEEP: state_nxt = EV_IDLE;
				default: state_nxt = EV_UP;
			endcase
		end else begin
			last_x_nxt = x_pos;
			last_y_nxt = y_pos;
			if (state == EV_IDLE) begin
				state_nxt = EV_DOWN;
				count_nxt = '0;
			end else if (state != EV_KEEPMOVE) begin
				// In keep the counter is frozen; in the other states that reach here it advances.
				if (state != EV_KEEP) begin
					count_nxt = count_inc;
				end
				if (hold_ok) begin
					state_nxt = move_ok ? EV_KEEPMOVE : EV_KEEP;
				end else if (move_ok) begin
					state_nxt = EV_MOVE;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/touch_gesture_classifier.sv @@
`default_nettype none

// Touch gesture classifier.
// Each input transaction on the s_ stream is one poll of a touch panel:
// s_tuser carries the touched flag and s_tdata the X and Y coordinates.
// For every input transaction exactly one output transaction leaves on the
// m_ stream, carrying the event code (idle, down, move, keep, keep-move, up,
// up after keep) that the poll leads to.
// The sample is captured in an input stage register, classified by short
// compare and subtract logic, and the event lands in the output register.
// m_tvalid rises when the sample moves from the input stage into the output
// register; throughput is one transaction per cycle while m_tready stays high.
// When the receiver stalls, the output register holds its event and the
// input stage can still take one more sample; s_tready drops only when both
// are occupied. The gesture state advances when a sample moves from the
// input stage to the output register, so events stay in poll order.
// The configuration port (cfg_we, cfg_index, cfg_data) sets the per-axis
// movement ranges and the hold limit; write it only while the block is idle.
// Reset returns the gesture to idle, clears the counter and coordinates,
// loads the default configuration and empties both stages.
module touch_gesture_classifier #(
	parameter int COORD_BITS = 12,
	parameter int COUNT_BITS = 8,
	localparam int IN_TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// Configuration write port.
	input  wire                                  cfg_we,
	input  wire  [tgc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire  [tgc_pkg::CFG_DATA_W-1:0]       cfg_data,
	// Poll samples.
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	input  wire  [IN_TDATA_W-1:0]                s_tdata,  // x_pos, y_pos, zero pad
	input  wire                                  s_tuser,  // touched
	// Events.
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	output logic [tgc_pkg::OUT_TDATA_W-1:0]      m_tdata   // event_code, zero pad
);
	import tgc_pkg::*;

	cfg_t cfg_q;

	// Input stage.
	logic                  valid_s1;
	logic                  touched_s1;
	logic [COORD_BITS-1:0] x_s1;
	logic [COORD_BITS-1:0] y_s1;

	// Gesture state.
	logic [EVENT_W-1:0]    state_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [COORD_BITS-1:0] last_x_q;
	logic [COORD_BITS-1:0] last_y_q;

	// Output register.
	logic                  out_valid_q;
	logic [EVENT_W-1:0]    out_code_q;

	logic [EVENT_W-1:0]    state_nxt;
	logic [COUNT_BITS-1:0] count_nxt;
	logic [COORD_BITS-1:0] last_x_nxt;
	logic [COORD_BITS-1:0] last_y_nxt;

	logic out_free;
	logic advance;
	logic s_fire;

	// The output register can load when empty or when its event is taken.
	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign s_fire   = s_tvalid && s_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W-EVENT_W){1'b0}}, out_code_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_range    <= X_RANGE_RST;
			cfg_q.y_range    <= Y_RANGE_RST;
			cfg_q.hold_limit <= HOLD_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_X_RANGE:    cfg_q.x_range    <= cfg_data[RANGE_W-1:0];
				CFG_Y_RANGE:    cfg_q.y_range    <= cfg_data[RANGE_W-1:0];
				CFG_HOLD_LIMIT: cfg_q.hold_limit <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			touched_s1 <= s_tuser;
			x_s1       <= s_tdata[COORD_BITS-1:0];
			y_s1       <= s_tdata[2*COORD_BITS-1:COORD_BITS];
		end
	end

	tgc_step #(
		.COORD_BITS (COORD_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_step (
		.cfg        (cfg_q),
		.state      (state_q),
		.count      (count_q),
		.last_x     (last_x_q),
		.last_y     (last_y_q),
		.touched    (touched_s1),
		.x_pos      (x_s1),
		.y_pos      (y_s1),
		.state_nxt  (state_nxt),
		.count_nxt  (count_nxt),
		.last_x_nxt (last_x_nxt),
		.last_y_nxt (last_y_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= EV_IDLE;
			count_q  <= '0;
			last_x_q <= '0;
			last_y_q <= '0;
		end else if (advance) begin
			state_q  <= state_nxt;
			count_q  <= count_nxt;
			last_x_q <= last_x_nxt;
			last_y_q <= last_y_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_code_q <= state_nxt;
		end
	end

`ifndef NO_ASSERTIONS
	// The reported event always matches the gesture state it was taken from.
	a_out_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (out_code_q == state_q))
		else $error("reported event differs from gesture state");

	// Back-pressure reaches the input only with both stages occupied.
	a_ready_low_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && out_valid_q))
		else $error("input stalled with a free stage");

	// A first touch reports down and clears the hold counter.
	a_first_touch: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && touched_s1 && (state_q == EV_IDLE))
		|=> ((state_q == EV_DOWN) && (count_q == '0)))
		else $error("first touch did not give down");

	// A release from keep always reports up after keep.
	a_release_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !touched_s1 && (state_q == EV_KEEP)) |=> (out_code_q == EV_UPKEEP))
		else $error("release from keep misreported");

	// Event codes never exceed the last defined code.
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_code_q <= EV_UPKEEP))
		else $error("event code out of range");
`endif

endmodule

`default_nettype wire

@@ verif/gesture_event_checker.sv @@
module gesture_event_checker #(
	parameter int COORD_BITS = 12,
	parameter int COUNT_BITS = 8,
	parameter int POLL_W     = 24
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_we,
	input  wire  [tgc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [tgc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire                             s_tvalid,
	input  wire                             s_tready,
	input  wire  [POLL_W-1:0]               s_tdata,  // x_pos, y_pos, zero pad
	input  wire                             s_tuser,  // touched
	input  wire                             m_tvalid,
	input  wire                             m_tready,
	input  wire  [tgc_pkg::OUT_TDATA_W-1:0] m_tdata,  // event_code, zero pad
	output int                              mismatch_count,
	output int                              events_in_flight
);
	import tgc_pkg::*;

	logic [RANGE_W-1:0]    x_span;
	logic [RANGE_W-1:0]    y_span;
	logic [LIMIT_W-1:0]    keep_after;
	logic [EVENT_W-1:0]    gesture;
	logic [COUNT_BITS-1:0] hold_cnt;
	logic [COORD_BITS-1:0] prev_x;
	logic [COORD_BITS-1:0] prev_y;
	logic [EVENT_W-1:0]    expected_events[$];

	function automatic logic [COORD_BITS-1:0] coord_gap(input logic [COORD_BITS-1:0] a,
		input logic [COORD_BITS-1:0] b);
		return (a < b) ? b - a : a - b;
	endfunction

	// Advances the gesture by one poll and returns the event it reports.
	task automatic classify_poll(input logic touched, input logic [COORD_BITS-1:0] x,
		input logic [COORD_BITS-1:0] y, output logic [EVENT_W-1:0] ev);
		logic held;
		logic moved;
		if (!touched) begin
			case (gesture)
				EV_IDLE: ;
				EV_KEEP: gesture = EV_UPKEEP;
				EV_UP, EV_UPKEEP: gesture = EV_IDLE;
				default: gesture = EV_UP;
			endcase
		end else begin
			if (gesture == EV_IDLE) begin
				gesture = EV_DOWN;
				hold_cnt = '0;
			end else if (gesture != EV_KEEPMOVE) begin
				held = (gesture == EV_KEEP);
				if (!held) begin
					if (hold_cnt != '1)
						hold_cnt = hold_cnt + 1'b1;
					held = (hold_cnt > keep_after);
				end
				// Movement is judged against the previous sample, before it is replaced.
				moved = (gesture == EV_MOVE) || (coord_gap(x, prev_x) > x_span) ||
					(coord_gap(y, prev_y) > y_span);
				if (held)
					gesture = moved ? EV_KEEPMOVE : EV_KEEP;
				else if (moved)
					gesture = EV_MOVE;
			end
			prev_x = x;
			prev_y = y;
		end
		ev = gesture;
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [EVENT_W-1:0] ev;
		if (!arst_n) begin
			x_span = X_RANGE_RST;
			y_span = Y_RANGE_RST;
			keep_after = HOLD_LIMIT_RST;
			gesture = EV_IDLE;
			hold_cnt = '0;
			prev_x = '0;
			prev_y = '0;
			expected_events.delete();
			mismatch_count <= 0;
			events_in_flight <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_X_RANGE:    x_span = cfg_data[RANGE_W-1:0];
					CFG_Y_RANGE:    y_span = cfg_data[RANGE_W-1:0];
					CFG_HOLD_LIMIT: keep_after = cfg_data[LIMIT_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				classify_poll(s_tuser, s_tdata[COORD_BITS-1:0],
					s_tdata[2*COORD_BITS-1:COORD_BITS], ev);
				expected_events.push_back(ev);
			end
			if (m_tvalid && m_tready) begin
				if (expected_events.size() == 0) begin
					$error("event_code: expected none, actual %0d", m_tdata[EVENT_W-1:0]);
					mismatch_count <= mismatch_count + 1;
				end else begin
					ev = expected_events.pop_front();
					if (m_tdata[EVENT_W-1:0] !== ev) begin
						$error("event_code: expected %0d, actual %0d", ev,
							m_tdata[EVENT_W-1:0]);
						mismatch_count <= mismatch_count + 1;
					end
				end
			end
			events_in_flight <= expected_events.size();
		end
	end

endmodule

@@ verif/testbench.sv @@
// Top of the touch gesture classifier bench. This module only produces
// stimulus and gives the verdict; the checker instance beside the block
// predicts every event and compares it with the output stream.
module testbench;
	import tgc_pkg::*;

	localparam int COORD_BITS    = 12;
	localparam int COUNT_BITS    = 8;
	localparam int POLL_W        = ((2 * COORD_BITS + 7) / 8) * 8;
	localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
	localparam int STALL_LIMIT   = 1000;
	localparam int LONG_HOLD_OFF = 120;
	localparam int SATURATING_PRESS = 300;

	// Index 3 is not mapped; a write there must leave the configuration alone.
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [POLL_W-1:0]      s_tdata = '0;   // x_pos, y_pos, zero pad
	logic                   s_tuser = 1'b0; // touched
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;        // event_code, zero pad

	int mismatch_count;
	int events_in_flight;
	int polls_sent = 0;
	int idle_cycles = 0;

	// Sender burstiness for the current stretch: zero means back-to-back polls.
	int gap_odds = 0;
	// Set in the last phase: neither side idles any more.
	bit calm = 1'b0;
	// Raised by the stimulus once; the receiver process then holds off on its own.
	bit want_long_stall = 1'b0;

	// Shadow of the configuration, used only to shape the gestures.
	int x_span_now = int'(X_RANGE_RST);
	int y_span_now = int'(Y_RANGE_RST);
	int hold_now = int'(HOLD_LIMIT_RST);

	always #2 clk = ~clk;

	touch_gesture_classifier #(
		.COORD_BITS(COORD_BITS),
		.COUNT_BITS(COUNT_BITS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	gesture_event_checker #(
		.COORD_BITS(COORD_BITS),
		.COUNT_BITS(COUNT_BITS),
		.POLL_W    (POLL_W)
	) events_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.mismatch_count  (mismatch_count),
		.events_in_flight(events_in_flight)
	);

	// The watchdog counts cycles in which neither stream moves a transaction.
	// Its limit covers the long receiver hold-off, the random gaps on both
	// sides and the short pauses around configuration writes many times over.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// Receiver. It stalls in random bursts, with quiet stretches where it never
	// stalls. On request it holds off for one long stretch so that both stages
	// of the block fill and s_tready drops while the sender keeps offering
	// polls. Exactly one assignment to m_tready per edge.
	initial begin
		int stall_left;
		int stall_odds;
		int cycle;
		stall_left = 0;
		stall_odds = 0;
		cycle = 0;
		forever begin
			@(posedge clk);
			cycle++;
			if (cycle % 64 == 0)
				stall_odds = $urandom_range(0, 3);
			if (want_long_stall) begin
				want_long_stall = 1'b0;
				stall_left = LONG_HOLD_OFF;
			end else if (stall_left == 0 && !calm && stall_odds != 0 &&
					$urandom_range(1, 8) <= stall_odds) begin
				stall_left = $urandom_range(1, 10);
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Offers one poll and returns at the edge where the transaction is taken.
	// A random gap may come first, unless the sender is in a quiet stretch.
	task automatic send_poll(input logic touched, input int x, input int y);
		if (!calm && gap_odds != 0 && $urandom_range(1, 8) <= gap_odds) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= touched;
		s_tdata <= POLL_W'({COORD_BITS'(y), COORD_BITS'(x)});
		do @(posedge clk); while (!s_tready);
		polls_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(input int x_span, input int y_span, input int hold);
		write_reg(CFG_X_RANGE, x_span);
		write_reg(CFG_Y_RANGE, y_span);
		write_reg(CFG_HOLD_LIMIT, hold);
		x_span_now = x_span;
		y_span_now = y_span;
		hold_now = hold;
	endtask

	// Stops offering and waits until every predicted event has come out, so
	// the block is idle before the configuration changes. The first edge lets
	// the checker's count catch up with the last accepted poll.
	task automatic wait_until_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (events_in_flight != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Next coordinate of a finger: mostly jitter inside the still range, some
	// steps right at the range edge, and some jumps anywhere on the panel.
	function automatic int nudge(input int base, input int span);
		int d;
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			d = $urandom_range(0, span);
		else if (pick < 8)
			d = span + $urandom_range(0, 1);
		else
			d = $urandom_range(0, COORD_MAX);
		if ($urandom_range(0, 1))
			d = -d;
		d = base + d;
		if (d < 0)
			d = 0;
		if (d > COORD_MAX)
			d = COORD_MAX;
		return d;
	endfunction

	// One press: a touch-down, a run of further touches, then one to three
	// releases. Sometimes the finger comes back right after the release, which
	// lands a touch in an up state or restarts from idle.
	task automatic play_gesture(input int touches);
		int px;
		int py;
		if ($urandom_range(0, 3) == 0) begin
			px = $urandom_range(0, 1) ? COORD_MAX : 0;
			py = $urandom_range(0, 1) ? COORD_MAX : 0;
		end else begin
			px = $urandom_range(0, COORD_MAX);
			py = $urandom_range(0, COORD_MAX);
		end
		send_poll(1'b1, px, py);
		repeat (touches) begin
			px = nudge(px, x_span_now);
			py = nudge(py, y_span_now);
			send_poll(1'b1, px, py);
		end
		repeat ($urandom_range(1, 3))
			send_poll(1'b0, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
		if ($urandom_range(0, 3) == 0) begin
			send_poll(1'b1, nudge(px, x_span_now), nudge(py, y_span_now));
			send_poll(1'b0, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
		end
	endtask

	initial begin
		int ph;
		int target;
		int most;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A write to the unmapped index first; the directed polls below rely on
		// the reset configuration (ranges 16, hold limit 5) still being in force.
		write_reg(CFG_UNMAPPED, $urandom_range(0, (1 << CFG_DATA_W) - 1));
		gap_odds = $urandom_range(0, 3);

		// Release while idle stays idle; then down at the origin.
		send_poll(1'b0, COORD_MAX, COORD_MAX);
		send_poll(1'b1, 0, 0);
		// Still finger stays down, a jump across X gives move, and move sticks.
		send_poll(1'b1, 0, 0);
		send_poll(1'b1, COORD_MAX, 0);
		send_poll(1'b1, COORD_MAX, COORD_MAX);
		// Release from move gives up; a still touch in up stays up; then idle.
		send_poll(1'b0, 0, 0);
		send_poll(1'b1, COORD_MAX, COORD_MAX);
		send_poll(1'b0, 0, 0);
		// Hold still past the limit: down five times more, then keep.
		send_poll(1'b1, 10, 10);
		repeat (6) send_poll(1'b1, 10, 10);
		// A step of exactly the range is still holding, so keep remains.
		send_poll(1'b1, 26, 10);
		// Release from keep gives up after keep; a touch there that moves one
		// past the Y range becomes keep-move, which ignores further touches.
		send_poll(1'b0, 0, 0);
		send_poll(1'b1, 26, 27);
		send_poll(1'b1, 0, COORD_MAX);
		// Release from keep-move gives up, then idle.
		send_poll(1'b0, 0, 0);
		send_poll(1'b0, 0, 0);

		for (ph = 0; ph < 6; ph++) begin
			wait_until_drained();
			case (ph)
				0: configure(0, 0, 0);
				1: configure(COORD_MAX, COORD_MAX, (1 << LIMIT_W) - 1);
				2: configure($urandom_range(0, 64), $urandom_range(0, 64),
					$urandom_range(0, 20));
				3: configure($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
					$urandom_range(0, (1 << LIMIT_W) - 1));
				4: configure(1, COORD_MAX, 1);
				default: configure(int'(X_RANGE_RST), int'(Y_RANGE_RST),
					int'(HOLD_LIMIT_RST));
			endcase
			if (ph == 1) begin
				// A press long enough to saturate the hold counter; with the
				// highest limit it never turns into keep.
				gap_odds = 0;
				repeat (SATURATING_PRESS) send_poll(1'b1, COORD_MAX, 0);
				send_poll(1'b0, 0, COORD_MAX);
				send_poll(1'b0, 0, COORD_MAX);
			end
			if (ph == 3)
				want_long_stall = 1'b1;
			if (ph == 5)
				calm = 1'b1;
			target = 25 + (ph + 1) * 255;
			while (polls_sent < target) begin
				gap_odds = $urandom_range(0, 3);
				if ($urandom_range(0, 4) == 0) begin
					// Noise: polls with every field random.
					repeat ($urandom_range(1, 5))
						send_poll(1'($urandom_range(0, 1)), $urandom_range(0, COORD_MAX),
							$urandom_range(0, COORD_MAX));
				end else begin
					most = hold_now + 8;
					if (most > 40)
						most = 40;
					play_gesture($urandom_range(0, most));
				end
			end
		end

		wait_until_drained();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && events_in_flight == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ touch_gesture_classifier.f @@
hdl/tgc_pkg.sv
hdl/tgc_step.sv
hdl/touch_gesture_classifier.sv
verif/gesture_event_checker.sv
verif/testbench.sv
